/* sv/dheap_pkg.sv */
// Shared constants and types for the d-ary min-heap priority queue.
// No dependencies; imported by dary_min_heap, its port checker and the testbench.
package dheap_pkg;

  localparam int ARITY       = 3;
  localparam int CAPACITY    = 1024;
  localparam int DATA_W      = 32;
  localparam int TOTAL_W     = 11;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int K_W         = $clog2(ARITY);
  localparam int FIRST_W     = IDX_W + $clog2(ARITY) + 1;
  // Parent index (i-1)/ARITY as a multiply by a rounded-up reciprocal; exact
  // for every index below 2**IDX_W.
  localparam int DIV_SH      = IDX_W + $clog2(ARITY);
  localparam int DIV_M       = ((1 << DIV_SH) + ARITY - 1) / ARITY;
  localparam int OUT_TDATA_W = ((2 * DATA_W + TOTAL_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

/* sv/dary_min_heap.sv */
// D-ary min-heap priority queue: heap memory, sift sequencer, result register.
// Depends on dheap_pkg.
//
// Usage:
//   Input channel (s_axis_*): one item per operation. tuser carries the
//   command (insert or remove minimum), tdata the signed value to insert.
//   Output channel (m_axis_*): exactly one item per input item, in order.
//   tdata carries removed value, new top value and element count; tuser
//   carries the status (ok, remove from empty, insert into full).
//
// Sequencing:
//   One item at a time; s_axis_tready is high only while the sequencer is
//   idle. The heap sits in a simple dual-port memory (one read and one write
//   a cycle, registered read data) and one signed comparator does the sift.
//   Insert: each parent compared takes a check state, which reads it, and a
//   compare state, which moves it down or writes the value; at the root
//   the check state writes the value.
//   Remove: a load state fetches the last element, then each level walked
//   down takes a read state and one compare state per child examined, at
//   most ARITY; the walk ends when it runs out of children or no child is
//   smaller. Rejected items (empty or full) and a remove of the only element
//   go straight to the result state, which returns to idle in the same
//   cycle as the result appears.
//
// Reset and stall:
//   Reset empties the heap (count to zero) and drops any waiting result; the
//   memory is not cleared, since only entries below the count are read.
//   A finished result waits in the output register; while the receiver
//   stalls with a result waiting, the next finished result holds the
//   sequencer in its final state until the register frees.
module dary_min_heap (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dheap_pkg::DATA_W-1:0]      s_axis_tdata,  // [31:0] value
  input  logic [0:0]                        s_axis_tuser,  // [0] cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] removed_value, [63:32] top_value, [74:64] element_total, rest zero
  output logic [dheap_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]                        m_axis_tuser   // [1:0] status
);
  import dheap_pkg::*;

  // Heap memory and its ports
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;
  logic [IDX_W-1:0]  raddr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;

  // Control state
  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic              m_valid;

  // Sift datapath
  logic [DATA_W-1:0] v;          // value being placed (the "hole" contents)
  logic [IDX_W-1:0]  pos;        // hole position
  logic [IDX_W-1:0]  par;        // parent of the hole during sift-up
  logic [IDX_W-1:0]  cmp_idx;    // child whose data arrives this cycle
  logic [K_W-1:0]    kcnt;       // child number within the current level
  logic [DATA_W-1:0] best_v;     // running minimum, seeded with the hole value
  logic [IDX_W-1:0]  best_i;     // its index, seeded with the hole position
  logic [DATA_W-1:0] top;        // mirror of heap entry zero
  logic [DATA_W-1:0] removed;
  status_t           status;

  // Result register
  logic [DATA_W-1:0]  o_removed;
  logic [DATA_W-1:0]  o_top;
  logic [TOTAL_W-1:0] o_total;
  status_t            o_status;

  // Decisions
  logic                    accept;
  cmd_t                    cmd_in;
  logic                    full;
  logic                    empty;
  logic [CNT_W-1:0]        count_m1;
  logic                    out_free;
  logic                    out_load;
  logic [IDX_W-1:0]        pos_m1;
  logic [IDX_W+DIV_SH:0]   div_prod;
  logic [IDX_W-1:0]        parent;
  logic [FIRST_W-1:0]      first;
  logic                    first_ok;
  logic [DATA_W-1:0]       cmp_a;
  logic [DATA_W-1:0]       cmp_b;
  logic                    cmp_lt;
  logic                    up_less;
  logic                    take;
  logic [DATA_W-1:0]       best_v_new;
  logic [IDX_W-1:0]        best_i_new;
  logic [CNT_W-1:0]        nidx;
  logic                    more;
  logic                    dn_less;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign cmd_in   = cmd_t'(s_axis_tuser[0]);
  assign full     = (count >= CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign count_m1 = count - CNT_W'(1);
  assign out_free = !m_valid || m_axis_tready;

  // Shared signed comparator: hole against parent on the way up, fetched
  // child against the running minimum on the way down
  assign cmp_a  = (state == S_UP_CMP) ? v : rdata;
  assign cmp_b  = (state == S_UP_CMP) ? rdata : best_v;
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  // Sift-up: parent of the hole
  assign pos_m1   = pos - IDX_W'(1);
  assign div_prod = (IDX_W+DIV_SH+1)'(pos_m1) * (IDX_W+DIV_SH+1)'(DIV_M);
  assign parent   = div_prod[DIV_SH +: IDX_W];
  assign up_less  = cmp_lt;

  // Sift-down: first child, running minimum over the hole and its children;
  // a child only displaces a strictly larger minimum, so the lowest index
  // wins a tie and a child equal to the hole never moves
  assign first      = FIRST_W'(pos) * FIRST_W'(ARITY) + FIRST_W'(1);
  assign first_ok   = first < FIRST_W'(count);
  assign take       = cmp_lt;
  assign best_v_new = take ? rdata : best_v;
  assign best_i_new = take ? cmp_idx : best_i;
  assign nidx       = CNT_W'(cmp_idx) + CNT_W'(1);
  assign more       = (kcnt != K_W'(ARITY - 1)) && (nidx < count);
  assign dn_less    = (best_i_new != pos);

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd_in == CMD_INSERT) begin
            state_next = full ? S_DONE : S_UP_CHK;
          end else if (empty || count == CNT_W'(1)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_DN_LOAD;
          end
        end
      end
      S_UP_CHK:  state_next = (pos == '0) ? S_DONE : S_UP_CMP;
      S_UP_CMP:  state_next = up_less ? S_UP_CHK : S_DONE;
      S_DN_LOAD: state_next = S_DN_RD;
      S_DN_RD:   state_next = first_ok ? S_DN_CMP : S_DONE;
      S_DN_CMP: begin
        if (more) begin
          state_next = S_DN_CMP;
        end else begin
          state_next = dn_less ? S_DN_RD : S_DONE;
        end
      end
      S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory controls, handshake, result load
  always_comb begin
    s_axis_tready = 1'b0;
    raddr         = '0;
    we            = 1'b0;
    waddr         = pos;
    wdata         = v;
    out_load      = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        raddr         = count_m1[IDX_W-1:0];   // last element, for a remove
      end
      S_UP_CHK: begin
        raddr = parent;
        we    = (pos == '0);
      end
      S_UP_CMP: begin
        we    = 1'b1;
        wdata = up_less ? rdata : v;
      end
      S_DN_RD: begin
        raddr = first[IDX_W-1:0];
        we    = !first_ok;
      end
      S_DN_CMP: begin
        raddr = nidx[IDX_W-1:0];
        we    = !more;
        wdata = dn_less ? best_v_new : v;
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (cmd_in == CMD_INSERT && !full) begin
          count <= count + CNT_W'(1);
        end else if (cmd_in == CMD_REMOVE && !empty) begin
          count <= count_m1;
        end
      end
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Sift datapath
  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      top <= wdata;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          v       <= s_axis_tdata;
          pos     <= count[IDX_W-1:0];
          removed <= '0;
          status  <= ST_OK;
          if (cmd_in == CMD_INSERT) begin
            if (full) begin
              status <= ST_FULL;
            end
          end else if (empty) begin
            status <= ST_EMPTY;
          end else begin
            removed <= top;
          end
        end
      end
      S_UP_CHK: begin
        par <= parent;
      end
      S_UP_CMP: begin
        if (up_less) begin
          pos <= par;
        end
      end
      S_DN_LOAD: begin
        v   <= rdata;
        pos <= '0;
      end
      S_DN_RD: begin
        cmp_idx <= first[IDX_W-1:0];
        kcnt    <= '0;
        best_v  <= v;
        best_i  <= pos;
      end
      S_DN_CMP: begin
        best_v <= best_v_new;
        best_i <= best_i_new;
        if (more) begin
          cmp_idx <= nidx[IDX_W-1:0];
          kcnt    <= kcnt + K_W'(1);
        end else if (dn_less) begin
          pos <= best_i_new;
        end
      end
      default: begin
        kcnt <= kcnt;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_removed <= removed;
      o_top     <= (count != '0) ? top : '0;
      o_total   <= TOTAL_W'(count);
      o_status  <= status;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = OUT_TDATA_W'({o_total, o_top, o_removed});
  assign m_axis_tuser  = o_status;

endmodule

/* sv/dheap_check.sv */
// Port-level checker for dary_min_heap, attached by the bind below.
// Depends on dheap_pkg.
module dheap_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [dheap_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                        m_axis_tuser
);
  import dheap_pkg::*;

  // One item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item was in progress");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  // A remove from an empty heap reports an empty heap
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |->
      (m_axis_tdata[2*DATA_W +: TOTAL_W] == '0 && m_axis_tdata[DATA_W-1:0] == '0))
    else $error("empty status with nonzero count or removed value");

  // An empty heap has no top value
  a_top_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2*DATA_W +: TOTAL_W] == '0) |->
      (m_axis_tdata[DATA_W +: DATA_W] == '0))
    else $error("nonzero top value with empty heap");

  // A rejected insert leaves a full heap
  a_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_FULL) |->
      (m_axis_tdata[2*DATA_W +: TOTAL_W] == TOTAL_W'(CAPACITY)
       && m_axis_tdata[DATA_W-1:0] == '0))
    else $error("full status with wrong count or removed value");

endmodule

bind dary_min_heap dheap_check u_dheap_check (.*);

/* verif/dary_min_heap_tb.sv */
// Self-checking testbench for the d-ary min-heap priority queue (dary_min_heap).
// Holds a heap scoreboard class with its own predictor and a stream-driving top module;
// depends on dheap_pkg for widths, capacity, arity and the command and status codes.

class heap_scoreboard;

  typedef struct packed {
    logic [dheap_pkg::DATA_W-1:0]  removed;
    logic [dheap_pkg::DATA_W-1:0]  top;
    logic [dheap_pkg::TOTAL_W-1:0] total;
    dheap_pkg::status_t            status;
  } heap_result_t;

  logic signed [dheap_pkg::DATA_W-1:0] heap_mem [dheap_pkg::CAPACITY];
  int unsigned  fill;
  heap_result_t pending_q [$];
  int unsigned  errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  function int unsigned count();
    return fill;
  endfunction

  function int unsigned pending();
    return pending_q.size();
  endfunction

  function void swap_slots(int unsigned a, int unsigned b);
    logic signed [dheap_pkg::DATA_W-1:0] t;
    t           = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  // Move toward the root while strictly smaller than the parent.
  function void bubble_up(int unsigned pos);
    int unsigned up;
    while (pos > 0) begin
      up = (pos - 1) / dheap_pkg::ARITY;
      if (!(heap_mem[pos] < heap_mem[up])) break;
      swap_slots(pos, up);
      pos = up;
    end
  endfunction

  // Move down toward the smallest existing child; the lowest index wins a tie.
  function void bubble_down(int unsigned pos);
    int unsigned first, best, k;
    forever begin
      first = pos * dheap_pkg::ARITY + 1;
      if (first >= fill) break;
      best = first;
      for (k = 1; k < dheap_pkg::ARITY; k++) begin
        if (first + k >= fill) break;
        if (heap_mem[first + k] < heap_mem[best]) best = first + k;
      end
      if (!(heap_mem[best] < heap_mem[pos])) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function void note_item(dheap_pkg::cmd_t op, logic [dheap_pkg::DATA_W-1:0] v);
    heap_result_t r;
    r        = '0;
    r.status = dheap_pkg::ST_OK;
    if (op == dheap_pkg::CMD_INSERT) begin
      if (fill >= dheap_pkg::CAPACITY) begin
        r.status = dheap_pkg::ST_FULL;
      end else begin
        heap_mem[fill] = v;
        bubble_up(fill);
        fill++;
      end
    end else begin
      if (fill == 0) begin
        r.status = dheap_pkg::ST_EMPTY;
      end else begin
        r.removed   = heap_mem[0];
        fill--;
        heap_mem[0] = heap_mem[fill];
        bubble_down(0);
      end
    end
    r.top   = (fill != 0) ? heap_mem[0] : '0;
    r.total = dheap_pkg::TOTAL_W'(fill);
    pending_q.push_back(r);
  endfunction

  function void report(string field, logic [dheap_pkg::DATA_W-1:0] want,
                       logic [dheap_pkg::DATA_W-1:0] got);
    $display("%0t ns: mismatch in %s: expected %h, actual %h", $time, field, want, got);
    errors++;
  endfunction

  function void check_result(logic [dheap_pkg::OUT_TDATA_W-1:0] tdata, logic [1:0] tuser);
    heap_result_t want;
    localparam int PAD_LO = 2 * dheap_pkg::DATA_W + dheap_pkg::TOTAL_W;
    if (pending_q.size() == 0) begin
      $display("%0t ns: unexpected result: expected none, actual tdata %h tuser %0d",
               $time, tdata, tuser);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (tdata[31:0] !== want.removed) report("removed_value", want.removed, tdata[31:0]);
    if (tdata[63:32] !== want.top) report("top_value", want.top, tdata[63:32]);
    if (tdata[74:64] !== want.total) report("element_total", 32'(want.total), 32'(tdata[74:64]));
    if (tdata[dheap_pkg::OUT_TDATA_W-1:PAD_LO] !== '0)
      report("tdata padding", '0, 32'(tdata[dheap_pkg::OUT_TDATA_W-1:PAD_LO]));
    if (tuser !== want.status) report("status", 32'(want.status), 32'(tuser));
  endfunction

endclass

module dary_min_heap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dheap_pkg::*;

  // Slowest run: ~950 items, each with the block's own time plus the longest gaps
  // on both sides, plus one long receiver hold; this is several times that.
  localparam longint LIMIT_NS    = 64'd12_000_000;
  localparam int     HOLD_AT     = 200;  // result count that starts the long hold-off
  localparam int     HOLD_CYCLES = 600;
  localparam int     TAIL_CYCLES = 64;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = CMD_INSERT;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  heap_scoreboard sb = new();

  bit send_burst = 1'b0;  // stretch with no sender gaps
  bit recv_burst = 1'b0;  // stretch with no receiver stalls
  int unsigned items_sent = 0;

  dary_min_heap DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] value
    .s_axis_tuser  (s_axis_tuser),   // [0] cmd
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] removed, [63:32] top, [74:64] total
    .m_axis_tuser  (m_axis_tuser)    // [1:0] status
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of extremes, a narrow band around zero to force ties, and full-range values.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000 + $urandom_range(0, 3);
      1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2, 3:    return $urandom_range(0, 8) - 4;
      default: return $urandom();
    endcase
  endfunction

  // Offer one item, hold it until accepted, then idle for a random gap.
  // tvalid stays high into the next item when there is no gap.
  task automatic push_item(input cmd_t op, input logic [DATA_W-1:0] v);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(op, v);
    items_sent++;
    if (items_sent % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Pick insert or remove with the given insert weight (percent).
  task automatic push_random(input int unsigned insert_pct);
    if ($urandom_range(0, 99) < insert_pct) push_item(CMD_INSERT, pick_value());
    else push_item(CMD_REMOVE, $urandom());
  endtask

  // Hold the input quiet until every outstanding result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted item, stall at random, and once hold off
  // long enough that the block fills its output stage and stalls its input.
  initial begin
    int unsigned stall_left;
    int unsigned results_seen;
    stall_left   = 0;
    results_seen = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser);
        results_seen++;
        if (results_seen % 128 == 0) recv_burst = ($urandom_range(0, 3) == 0);
        if (results_seen == HOLD_AT) stall_left = HOLD_CYCLES;
        else if (!recv_burst) stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: remove from empty, field extremes, ties, then drain past empty.
    push_item(CMD_REMOVE, 32'hFFFF_FFFF);
    push_item(CMD_INSERT, 32'h7FFF_FFFF);
    push_item(CMD_INSERT, 32'h8000_0000);
    push_item(CMD_INSERT, 32'h0000_0000);
    push_item(CMD_INSERT, 32'hFFFF_FFFF);
    push_item(CMD_INSERT, 32'hAAAA_AAAA);
    push_item(CMD_INSERT, 32'h5555_5555);
    push_item(CMD_INSERT, 32'd5);
    push_item(CMD_INSERT, 32'd5);
    push_item(CMD_INSERT, 32'd5);
    push_item(CMD_INSERT, 32'h8000_0000);
    for (n = 0; n < 12; n++) push_item(CMD_REMOVE, 32'h0000_0000);
    wait_drained();

    // Mixed traffic near empty: removes from empty act as noise.
    for (n = 0; n < 150; n++) push_random(58);
    wait_drained();

    // Grow a deep heap: long sift-up walks with removes mixed in.
    for (n = 0; n < 600; n++) push_random(85);
    wait_drained();

    // Remove-heavy: long sift-down walks through a deep heap.
    for (n = 0; n < 180; n++) push_random(20);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("dary_min_heap_tb passed");
    else $display("dary_min_heap_tb failed");
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("dary_min_heap_tb failed");
    $finish;
  end

endmodule

/* sim.f */
sv/dheap_pkg.sv
sv/dary_min_heap.sv
sv/dheap_check.sv
verif/dary_min_heap_tb.sv
